[rtl/hlid_pkg.sv]
// Shared types and constants for the holey slot list.
// Used by hlid_cell, hlid_status and the top level; depends on nothing.
`default_nettype none

package hlid_pkg;

    // Default row length and fixed field widths
    localparam int SLOT_COUNT_DEF = 128;
    localparam int VALUE_W        = 8;
    localparam int ACTION_W       = 3;
    localparam int INDEX_W        = 7;
    localparam int COUNT_W        = 8;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_INSERT_AT    = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_INSERT_FIRST = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_APPEND       = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_DELETE_AT    = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_DELETE_FIRST = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_DELETE_LAST  = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_CLEAR        = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_READ         = 3'd7;

    // Hole marker
    localparam logic [VALUE_W-1:0] HOLE = '0;

    // Command broadcast to every cell of the row
    typedef struct packed {
        logic clear;   // all cells become holes
        logic write;   // cell at pos takes the new byte
        logic shift;   // cells above pos take their left neighbor
        logic erase;   // cell at pos becomes a hole
    } cell_cmd_t;

endpackage

`default_nettype wire

[rtl/hlid_cell.sv]
// One slot of the row: holds a byte and takes from its left neighbor on a shift.
// Depends on hlid_pkg.
`default_nettype none

module hlid_cell
    import hlid_pkg::*;
#(
    parameter int IDX_W    = 7,
    parameter int CELL_IDX = 0
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire cell_cmd_t          cmd,
    input  wire logic [IDX_W-1:0]   pos,
    input  wire logic [VALUE_W-1:0] wr_value,
    input  wire logic [VALUE_W-1:0] left_value,
    output logic      [VALUE_W-1:0] value,
    output logic                    occupied,
    output logic      [VALUE_W-1:0] sel_value
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic [VALUE_W-1:0] value_reg;
    logic [VALUE_W-1:0] value_next;
    logic               hit;

    assign hit = (pos == MY_IDX);

    // Next slot content, clear first, then write, shift, erase
    always_comb begin
        value_next = value_reg;
        if (cmd.clear) begin
            value_next = HOLE;
        end else if (cmd.write && hit) begin
            value_next = wr_value;
        end else if (cmd.shift && (MY_IDX > pos)) begin
            value_next = left_value;
        end else if (cmd.erase && hit) begin
            value_next = HOLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_reg <= HOLE;
        end else begin
            value_reg <= value_next;
        end
    end

    assign value     = value_reg;
    assign occupied  = (value_reg != HOLE);
    assign sel_value = hit ? value_reg : HOLE;

endmodule

`default_nettype wire

[rtl/hlid_status.sv]
// Priority encoders over the occupancy bits: lowest and highest occupied slot.
// Depends on hlid_pkg for the default slot count; purely combinational.
`default_nettype none

module hlid_status
    import hlid_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  wire logic [SLOT_COUNT-1:0]         occ,
    output logic      [$clog2(SLOT_COUNT)-1:0] first_slot,
    output logic      [$clog2(SLOT_COUNT)-1:0] last_slot
);

    localparam int IDX_W = $clog2(SLOT_COUNT);

    logic [SLOT_COUNT-1:0] occ_rev;
    logic [SLOT_COUNT-1:0] lo_hot;
    logic [SLOT_COUNT-1:0] hi_hot;
    logic [IDX_W-1:0]      lo_enc;
    logic [IDX_W-1:0]      hi_enc;
    logic                  any_occ;

    // Reverse so the highest slot can use the same lowest-bit isolation
    always_comb begin
        for (int k = 0; k < SLOT_COUNT; k++) begin
            occ_rev[k] = occ[SLOT_COUNT-1-k];
        end
    end

    // Isolate lowest set bit: x & -x
    assign lo_hot  = occ & (~occ + SLOT_COUNT'(1));
    assign hi_hot  = occ_rev & (~occ_rev + SLOT_COUNT'(1));
    assign any_occ = |occ;

    // One-hot to binary
    always_comb begin
        lo_enc = '0;
        hi_enc = '0;
        for (int k = 0; k < SLOT_COUNT; k++) begin
            if (lo_hot[k]) lo_enc = lo_enc | IDX_W'(k);
            if (hi_hot[k]) hi_enc = hi_enc | IDX_W'(k);
        end
    end

    assign first_slot = any_occ ? lo_enc : '0;
    assign last_slot  = any_occ ? (IDX_W'(SLOT_COUNT - 1) - hi_enc) : '0;

endmodule

`default_nettype wire

[rtl/holey_list_insert_delete.sv]
// Holey slot list built as a row of byte cells with shift-right insertion.
// Top level; depends on hlid_pkg, hlid_cell and hlid_status.
//
// Usage:
//   s_ channel carries one operation per item: action, slot_index, new_value.
//   m_ channel returns one result item per operation: the byte taken, the
//   occupied count, first and last occupied slots, empty, full and error flags,
//   all describing the list after the operation.
//   An accepted item updates every cell in the same clock edge (shifts run in
//   parallel along the row). The ST_SCAN state then runs the first/last priority
//   encoders and loads the output register; the block takes no new item until
//   that load, so each operation finishes before the next one is accepted.
//   s_tready is high while no operation is in progress; it stays high while a
//   finished result waits in the output register. If the receiver stalls and
//   the output register is still full, the block holds the new result in its
//   encoder stage and stops accepting until the register frees.
//   Reset (aresetn low, synchronous) turns every slot into a hole, clears the
//   count and drops m_tvalid. No clearing pass is needed: cells reset at once.
`default_nettype none

module holey_list_insert_delete
    import hlid_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // action[2:0], slot_index[9:3], new_value[17:10], zero fill [23:18]
    input  wire logic [23:0] s_tdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // taken_value[7:0], item_count[15:8], first_slot[22:16], last_slot[29:23],
    // list_empty[30], list_full[31], op_error[32], zero fill [39:33]
    output logic      [39:0] m_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready
);

    localparam int IDX_W = $clog2(SLOT_COUNT);
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);
    localparam int CMP_W = (IDX_W + 1 > 8) ? IDX_W + 1 : 8;
    localparam int CWD_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam int SWD_W = (IDX_W > INDEX_W) ? IDX_W : INDEX_W;
    localparam logic [CMP_W-1:0] SLOT_EXT = CMP_W'(SLOT_COUNT);
    localparam logic [CMP_W-1:0] LAST_EXT = CMP_W'(SLOT_COUNT - 1);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t state_reg;

    // Input fields
    logic [ACTION_W-1:0] in_action;
    logic [INDEX_W-1:0]  in_index;
    logic [VALUE_W-1:0]  in_value;
    logic                in_fire;

    assign in_action = s_tdata[2:0];
    assign in_index  = s_tdata[9:3];
    assign in_value  = s_tdata[17:10];
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;

    // List status kept between items
    logic [CNT_W-1:0] count_reg;
    logic [IDX_W-1:0] first_reg;
    logic [IDX_W-1:0] last_reg;
    logic [VALUE_W-1:0] taken_reg;
    logic               err_reg;

    // Output register
    logic [VALUE_W-1:0] out_taken_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic [INDEX_W-1:0] out_first_reg;
    logic [INDEX_W-1:0] out_last_reg;
    logic               out_empty_reg;
    logic               out_full_reg;
    logic               out_err_reg;
    logic               m_tvalid_reg;

    // Row of cells
    logic [VALUE_W-1:0]    cell_value [SLOT_COUNT];
    logic [VALUE_W-1:0]    cell_sel   [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] cell_occ;
    cell_cmd_t             cmd;
    cell_cmd_t             cmd_eff;
    logic [CMP_W-1:0]      pos_ext;
    logic [IDX_W-1:0]      cell_pos;
    logic [VALUE_W-1:0]    sel_value;

    // Decode
    logic [CMP_W-1:0] idx_ext;
    logic [CMP_W-1:0] first_ext;
    logic [CMP_W-1:0] last_ext;
    logic [CMP_W-1:0] ins_pos;
    logic [CMP_W-1:0] del_pos;
    logic             cnt_nz;
    logic             shift_need;
    logic             ins_ok;
    logic             do_take;
    logic             err_next;
    logic [CNT_W-1:0] count_next;
    logic [VALUE_W-1:0] taken_next;

    assign idx_ext   = CMP_W'(in_index);
    assign first_ext = CMP_W'(first_reg);
    assign last_ext  = CMP_W'(last_reg);
    assign cnt_nz    = (count_reg != '0);

    // Insert and delete positions from the current status
    always_comb begin
        case (in_action)
            ACT_INSERT_FIRST: ins_pos = cnt_nz ? first_ext : '0;
            ACT_APPEND:       ins_pos = cnt_nz ? (last_ext + CMP_W'(1)) : '0;
            default:          ins_pos = idx_ext;
        endcase
        case (in_action)
            ACT_DELETE_FIRST: del_pos = first_ext;
            ACT_DELETE_LAST:  del_pos = last_ext;
            default:          del_pos = idx_ext;
        endcase
    end

    // Cell address for the current action
    always_comb begin
        case (in_action)
            ACT_INSERT_AT, ACT_INSERT_FIRST, ACT_APPEND:      pos_ext = ins_pos;
            ACT_DELETE_AT, ACT_DELETE_FIRST, ACT_DELETE_LAST: pos_ext = del_pos;
            default:                                          pos_ext = idx_ext;
        endcase
    end

    assign shift_need = cnt_nz && (last_ext >= ins_pos);
    assign ins_ok     = (in_value != HOLE) && (ins_pos < SLOT_EXT)
                        && !(shift_need && (last_ext == LAST_EXT));

    // Operation decode: cell command, count update, error
    always_comb begin
        cmd        = '0;
        do_take    = 1'b0;
        err_next   = 1'b0;
        count_next = count_reg;
        case (in_action)
            ACT_INSERT_AT, ACT_INSERT_FIRST, ACT_APPEND: begin
                if (ins_ok) begin
                    cmd.write  = 1'b1;
                    cmd.shift  = shift_need;
                    count_next = count_reg + CNT_W'(1);
                end else begin
                    err_next = 1'b1;
                end
            end
            ACT_DELETE_AT, ACT_DELETE_FIRST, ACT_DELETE_LAST: begin
                if (cnt_nz && (del_pos < SLOT_EXT)) begin
                    cmd.erase = 1'b1;
                    do_take   = 1'b1;
                    if (sel_value != HOLE) begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end else begin
                    err_next = 1'b1;
                end
            end
            ACT_CLEAR: begin
                cmd.clear  = 1'b1;
                count_next = '0;
            end
            ACT_READ: begin
                if (idx_ext < SLOT_EXT) begin
                    do_take = 1'b1;
                end else begin
                    err_next = 1'b1;
                end
            end
            default: begin
                err_next = 1'b1;
            end
        endcase
    end

    assign cell_pos   = pos_ext[IDX_W-1:0];
    assign cmd_eff    = in_fire ? cmd : '0;
    assign taken_next = do_take ? sel_value : HOLE;

    // The chain: cell k takes from cell k-1, slot 0 takes a hole
    for (genvar k = 0; k < SLOT_COUNT; k++) begin : g_cell
        logic [VALUE_W-1:0] left;
        if (k == 0) begin : g_head
            assign left = HOLE;
        end else begin : g_link
            assign left = cell_value[k-1];
        end
        hlid_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (k)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cmd        (cmd_eff),
            .pos        (cell_pos),
            .wr_value   (in_value),
            .left_value (left),
            .value      (cell_value[k]),
            .occupied   (cell_occ[k]),
            .sel_value  (cell_sel[k])
        );
    end

    // Only the addressed cell drives a non-zero byte
    always_comb begin
        sel_value = HOLE;
        for (int k = 0; k < SLOT_COUNT; k++) begin
            sel_value = sel_value | cell_sel[k];
        end
    end

    // First and last occupied slots after the update
    logic [IDX_W-1:0] scan_first;
    logic [IDX_W-1:0] scan_last;

    hlid_status #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_status (
        .occ        (cell_occ),
        .first_slot (scan_first),
        .last_slot  (scan_last)
    );

    logic [CWD_W-1:0] count_wide;
    logic [SWD_W-1:0] first_wide;
    logic [SWD_W-1:0] last_wide;
    logic             out_load;

    assign count_wide = CWD_W'(count_reg);
    assign first_wide = SWD_W'(scan_first);
    assign last_wide  = SWD_W'(scan_last);
    assign out_load   = (state_reg == ST_SCAN) && (!m_tvalid_reg || m_tready);

    // Sequencer, status and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            first_reg    <= '0;
            last_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (in_fire) begin
                        count_reg <= count_next;
                        taken_reg <= err_next ? HOLE : taken_next;
                        err_reg   <= err_next;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (out_load) begin
                        first_reg <= scan_first;
                        last_reg  <= scan_last;
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (out_load) begin
                m_tvalid_reg  <= 1'b1;
                out_taken_reg <= taken_reg;
                out_count_reg <= count_wide[COUNT_W-1:0];
                out_first_reg <= first_wide[INDEX_W-1:0];
                out_last_reg  <= last_wide[INDEX_W-1:0];
                out_empty_reg <= (count_reg == '0);
                out_full_reg  <= (count_reg == CNT_W'(SLOT_COUNT));
                out_err_reg   <= err_reg;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, out_err_reg, out_full_reg, out_empty_reg, out_last_reg,
                       out_first_reg, out_count_reg, out_taken_reg};

endmodule

`default_nettype wire

[rtl/hlid_checker.sv]
// Port-level checks on result items of the holey slot list, bound to the top.
// Depends on holey_list_insert_delete's port list only.
`default_nettype none

module hlid_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic [39:0] m_tdata,
    input wire logic        m_tvalid
);

    logic [7:0] taken;
    logic [7:0] count;
    logic [6:0] first;
    logic [6:0] last;
    logic       empty;
    logic       err;

    assign taken = m_tdata[7:0];
    assign count = m_tdata[15:8];
    assign first = m_tdata[22:16];
    assign last  = m_tdata[29:23];
    assign empty = m_tdata[30];
    assign err   = m_tdata[32];

    // A refused item returns no byte
    a_err_no_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && err) |-> (taken == 8'd0))
        else $error("refused item returned a byte");

    // Empty flag agrees with the count
    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (empty == (count == 8'd0)))
        else $error("empty flag disagrees with count");

    // Empty list reports slot zero for both ends
    a_empty_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && empty) |-> ((first == 7'd0) && (last == 7'd0)))
        else $error("empty list reports non-zero ends");

    // First occupied slot never lies above the last
    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (first <= last))
        else $error("first slot above last slot");

    // No result item right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result item out of reset");

endmodule

bind holey_list_insert_delete hlid_checker u_hlid_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid)
);

`default_nettype wire
